// ----- hdl/dcs_pkg.sv -----
// ----------------------------------------------------------------------------
// dcs_pkg
// Types, codes and constants shared by the drill cycle sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dcs_pkg;

  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned InDataWidth  = 48;
  localparam int unsigned OutDataWidth = 24;

  localparam logic [CfgWidth-1:0] DebounceReset = 16'd250;
  localparam logic [CfgWidth-1:0] RearmReset    = 16'd1000;
  localparam logic [7:0]          DepthMax      = 8'd200;

  localparam logic [CfgIdxWidth-1:0] RegDebounce = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegRearm    = 1'b1;

  localparam logic OpTick    = 1'b0;
  localparam logic OpTrigger = 1'b1;

  typedef enum logic [2:0] {
    PH_SPEED   = 3'd0,
    PH_MODE    = 3'd1,
    PH_DEPTH   = 3'd2,
    PH_READY   = 3'd3,
    PH_DESCENT = 3'd4,
    PH_RETURN  = 3'd5,
    PH_EMERG   = 3'd6
  } phase_e;

  typedef struct packed {
    logic                 opcode;
    logic [TimeWidth-1:0] now_ms;
    logic [1:0]           speed_choice;
    logic                 mode_fixed_choice;
    logic [7:0]           depth_choice;
    logic                 validate_button;
    logic                 start_button;
    logic                 descent_finished;
    logic                 return_finished;
    logic                 estop_level;
  } item_t;

  typedef struct packed {
    phase_e               phase;
    logic [1:0]           speed_level;
    logic                 preset_mode;
    logic [7:0]           depth_mm;
    logic                 emergency_flag;
    logic [TimeWidth-1:0] last_press_ms;
    logic                 release_seen;
  } state_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] chosen_speed;
    logic       fixed_mode;
    logic [7:0] chosen_depth;
    logic       prepare_descent;
    logic       motor_halt;
    logic       motor_reenable;
    logic       step_down;
    logic       drive_return;
    logic       emergency_latched;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/dcs_step.sv -----
// ----------------------------------------------------------------------------
// dcs_step
// One sequencer step: next state and result for one item, combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_step (
  input  wire logic [dcs_pkg::CfgWidth-1:0] debounce_ms_i,
  input  wire logic [dcs_pkg::CfgWidth-1:0] rearm_delay_ms_i,
  input  wire dcs_pkg::state_t              state_i,
  input  wire dcs_pkg::item_t               item_i,
  output dcs_pkg::state_t                   state_o,
  output dcs_pkg::result_t                  result_o
);
  import dcs_pkg::*;

  logic [TimeWidth-1:0] elapsed;
  logic                 press_ok;
  logic                 rel;
  logic                 prep;
  logic                 halt;
  logic                 reen;
  logic                 stepd;
  logic                 drv;
  state_t               nxt;

  assign elapsed  = item_i.now_ms - state_i.last_press_ms;
  assign press_ok = item_i.validate_button &&
                    (elapsed >= {{(TimeWidth-CfgWidth){1'b0}}, debounce_ms_i});
  assign rel      = state_i.release_seen || !item_i.estop_level;

  always_comb begin
    nxt   = state_i;
    prep  = 1'b0;
    halt  = 1'b0;
    reen  = 1'b0;
    stepd = 1'b0;
    drv   = 1'b0;
    if (item_i.opcode == OpTrigger) begin
      if (!state_i.emergency_flag) begin
        nxt.emergency_flag = 1'b1;
        nxt.last_press_ms  = item_i.now_ms;
        halt               = 1'b1;
      end
    end else begin
      if (state_i.emergency_flag) begin
        nxt.phase = PH_EMERG;
      end
      case (nxt.phase)
        PH_SPEED: begin
          nxt.speed_level = (item_i.speed_choice == 2'd0) ? 2'd1 : item_i.speed_choice;
          if (press_ok) begin
            nxt.last_press_ms = item_i.now_ms;
            nxt.phase         = PH_MODE;
          end
        end
        PH_MODE: begin
          nxt.preset_mode = item_i.mode_fixed_choice;
          if (press_ok) begin
            nxt.last_press_ms = item_i.now_ms;
            nxt.phase         = item_i.mode_fixed_choice ? PH_READY : PH_DEPTH;
          end
        end
        PH_DEPTH: begin
          if (item_i.depth_choice == 8'd0) begin
            nxt.depth_mm = 8'd1;
          end else if (item_i.depth_choice > DepthMax) begin
            nxt.depth_mm = DepthMax;
          end else begin
            nxt.depth_mm = item_i.depth_choice;
          end
          if (press_ok) begin
            nxt.last_press_ms = item_i.now_ms;
            nxt.phase         = PH_READY;
          end
        end
        PH_READY: begin
          if (item_i.start_button) begin
            prep      = 1'b1;
            nxt.phase = PH_DESCENT;
          end
        end
        PH_DESCENT: begin
          stepd = 1'b1;
          if (item_i.descent_finished) begin
            nxt.phase = PH_RETURN;
          end
        end
        PH_RETURN: begin
          drv = 1'b1;
          if (item_i.return_finished) begin
            nxt.phase = PH_SPEED;
          end
        end
        PH_EMERG: begin
          nxt.release_seen = rel;
          if (rel && item_i.estop_level &&
              (elapsed > {{(TimeWidth-CfgWidth){1'b0}}, rearm_delay_ms_i})) begin
            nxt.release_seen   = 1'b0;
            nxt.emergency_flag = 1'b0;
            nxt.last_press_ms  = item_i.now_ms;
            reen               = 1'b1;
            nxt.phase          = PH_SPEED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign state_o = nxt;

  assign result_o.phase             = nxt.phase;
  assign result_o.chosen_speed      = nxt.speed_level;
  assign result_o.fixed_mode        = nxt.preset_mode;
  assign result_o.chosen_depth      = nxt.depth_mm;
  assign result_o.prepare_descent   = prep;
  assign result_o.motor_halt        = halt;
  assign result_o.motor_reenable    = reen;
  assign result_o.step_down         = stepd;
  assign result_o.drive_return      = drv;
  assign result_o.emergency_latched = nxt.emergency_flag;

endmodule

`default_nettype wire

// ----- hdl/drill_cycle_sequencer.sv -----
// ----------------------------------------------------------------------------
// drill_cycle_sequencer
// Drilling cycle sequencer: menus, debounce, descent/return and e-stop rearm.
// ----------------------------------------------------------------------------
//  Channel   Direction  Per transfer
//  s_axis    in         one tick or emergency trigger
//  m_axis    out        one result per input transfer
//  cfg       in         register write, no read-back
//
//  Input register, one combinational step, result register; one transfer per
//  cycle sustained while m_axis does not stall.
//  The result register frees the input side while a result waits; a stalled
//  m_axis backs up through the input register to s_axis_tready.
//  Reset clears the sequencer state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module drill_cycle_sequencer (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // now_ms[31:0], speed_choice[33:32], mode_fixed_choice[34], depth_choice[42:35],
  // validate_button[43], start_button[44], descent_finished[45],
  // return_finished[46], estop_level[47]
  input  wire logic [dcs_pkg::InDataWidth-1:0]     s_axis_tdata,
  // opcode[0]
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // phase[2:0], chosen_speed[4:3], fixed_mode[5], chosen_depth[13:6],
  // prepare_descent[14], motor_halt[15], motor_reenable[16], step_down[17],
  // drive_return[18], emergency_latched[19], zero[23:20]
  output logic [dcs_pkg::OutDataWidth-1:0]         m_axis_tdata,
  input  wire logic                                cfg_we_i,
  input  wire logic [dcs_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  wire logic [dcs_pkg::CfgWidth-1:0]        cfg_wdata_i
);
  import dcs_pkg::*;

  logic [CfgWidth-1:0] debounce_q;
  logic [CfgWidth-1:0] rearm_q;
  logic                in_valid_q;
  item_t               in_item_q;
  item_t               in_item_d;
  logic                out_valid_q;
  result_t             out_res_q;
  result_t             out_res_d;
  state_t              state_q;
  state_t              state_d;
  logic                advance;
  logic                in_take;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign in_item_d.opcode            = s_axis_tuser;
  assign in_item_d.now_ms            = s_axis_tdata[31:0];
  assign in_item_d.speed_choice      = s_axis_tdata[33:32];
  assign in_item_d.mode_fixed_choice = s_axis_tdata[34];
  assign in_item_d.depth_choice      = s_axis_tdata[42:35];
  assign in_item_d.validate_button   = s_axis_tdata[43];
  assign in_item_d.start_button      = s_axis_tdata[44];
  assign in_item_d.descent_finished  = s_axis_tdata[45];
  assign in_item_d.return_finished   = s_axis_tdata[46];
  assign in_item_d.estop_level       = s_axis_tdata[47];

  dcs_step u_step (
    .debounce_ms_i    (debounce_q),
    .rearm_delay_ms_i (rearm_q),
    .state_i          (state_q),
    .item_i           (in_item_q),
    .state_o          (state_d),
    .result_o         (out_res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
      rearm_q    <= RearmReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDebounce: debounce_q <= cfg_wdata_i;
        RegRearm:    rearm_q    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q.phase          <= PH_SPEED;
      state_q.speed_level    <= 2'd1;
      state_q.preset_mode    <= 1'b1;
      state_q.depth_mm       <= 8'd0;
      state_q.emergency_flag <= 1'b0;
      state_q.last_press_ms  <= '0;
      state_q.release_seen   <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_d;
    end
    if (advance) begin
      out_res_q <= out_res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000,
                          out_res_q.emergency_latched,
                          out_res_q.drive_return,
                          out_res_q.step_down,
                          out_res_q.motor_reenable,
                          out_res_q.motor_halt,
                          out_res_q.prepare_descent,
                          out_res_q.chosen_depth,
                          out_res_q.fixed_mode,
                          out_res_q.chosen_speed,
                          out_res_q.phase};

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the drill cycle sequencer. Every transfer on s_axis runs through a
// local model of the sequencer, and the result on m_axis must match it.
// A short directed run covers the menus, the depth clamps, descent, return,
// emergency latch and rearm across a time wrap. Random traffic follows, mostly
// state-aware cycles with some fully random noise, under six register
// settings. Both sides insert random gaps.
// ----------------------------------------------------------------------------

import dcs_pkg::*;

class drill_scoreboard;
  logic [15:0] debounce;
  logic [15:0] rearm;
  phase_e      phase;
  logic [1:0]  speed;
  logic        preset;
  logic [7:0]  depth;
  logic        emerg;
  logic [31:0] last_press;
  logic        release_seen;
  result_t     pending[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned halts;
  int unsigned reenables;
  int unsigned preps;

  function new();
    debounce     = DebounceReset;
    rearm        = RearmReset;
    phase        = PH_SPEED;
    speed        = 2'd1;
    preset       = 1'b1;
    depth        = 8'd0;
    emerg        = 1'b0;
    last_press   = '0;
    release_seen = 1'b0;
    errors       = 0;
    checked      = 0;
    halts        = 0;
    reenables    = 0;
    preps        = 0;
  endfunction

  function void set_reg(logic [CfgIdxWidth-1:0] idx, logic [15:0] val);
    if (idx == RegDebounce) begin
      debounce = val;
    end else begin
      rearm = val;
    end
  endfunction

  function bit press_ok(logic [31:0] now);
    logic [31:0] diff;
    diff = now - last_press;
    if (diff < {16'd0, debounce}) return 1'b0;
    last_press = now;
    return 1'b1;
  endfunction

  function void note_input(item_t it);
    result_t     r;
    logic [31:0] diff;
    r = '0;
    if (it.opcode == OpTrigger) begin
      if (!emerg) begin
        emerg       = 1'b1;
        last_press  = it.now_ms;
        r.motor_halt = 1'b1;
        halts++;
      end
    end else begin
      if (emerg) phase = PH_EMERG;
      case (phase)
        PH_SPEED: begin
          speed = (it.speed_choice == 2'd0) ? 2'd1 : it.speed_choice;
          if (it.validate_button && press_ok(it.now_ms)) phase = PH_MODE;
        end
        PH_MODE: begin
          preset = it.mode_fixed_choice;
          if (it.validate_button && press_ok(it.now_ms)) begin
            phase = preset ? PH_READY : PH_DEPTH;
          end
        end
        PH_DEPTH: begin
          if (it.depth_choice == 8'd0) begin
            depth = 8'd1;
          end else if (it.depth_choice > DepthMax) begin
            depth = DepthMax;
          end else begin
            depth = it.depth_choice;
          end
          if (it.validate_button && press_ok(it.now_ms)) phase = PH_READY;
        end
        PH_READY: begin
          if (it.start_button) begin
            r.prepare_descent = 1'b1;
            phase = PH_DESCENT;
            preps++;
          end
        end
        PH_DESCENT: begin
          r.step_down = 1'b1;
          if (it.descent_finished) phase = PH_RETURN;
        end
        PH_RETURN: begin
          r.drive_return = 1'b1;
          if (it.return_finished) phase = PH_SPEED;
        end
        PH_EMERG: begin
          if (!it.estop_level) release_seen = 1'b1;
          diff = it.now_ms - last_press;
          if (release_seen && it.estop_level && diff > {16'd0, rearm}) begin
            release_seen     = 1'b0;
            emerg            = 1'b0;
            last_press       = it.now_ms;
            r.motor_reenable = 1'b1;
            phase            = PH_SPEED;
            reenables++;
          end
        end
        default: begin
        end
      endcase
    end
    r.phase             = phase;
    r.chosen_speed      = speed;
    r.fixed_mode        = preset;
    r.chosen_depth      = depth;
    r.emergency_latched = emerg;
    pending.push_back(r);
  endfunction

  function void cmp(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  function void check_result(logic [OutDataWidth-1:0] d);
    result_t e;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: result %h expected none actual arrived", $time, d);
      return;
    end
    e = pending.pop_front();
    checked++;
    cmp("phase", e.phase, d[2:0]);
    cmp("chosen_speed", e.chosen_speed, d[4:3]);
    cmp("fixed_mode", e.fixed_mode, d[5]);
    cmp("chosen_depth", e.chosen_depth, d[13:6]);
    cmp("prepare_descent", e.prepare_descent, d[14]);
    cmp("motor_halt", e.motor_halt, d[15]);
    cmp("motor_reenable", e.motor_reenable, d[16]);
    cmp("step_down", e.step_down, d[17]);
    cmp("drive_return", e.drive_return, d[18]);
    cmp("emergency_latched", e.emergency_latched, d[19]);
    cmp("pad", 0, d[23:20]);
  endfunction
endclass

module testbench;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ItemsPerSetting = 320;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    s_axis_tuser = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i = '0;
  logic [CfgWidth-1:0]     cfg_wdata_i = '0;

  drill_scoreboard sb = new();
  logic [31:0]     t_now = '0;
  int unsigned     tx_left = 0;
  bit              tx_calm = 1'b0;
  int unsigned     stall_cycles = 0;
  int unsigned     settings_run = 0;

  drill_cycle_sequencer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic item_t mk(logic op, logic [31:0] now, logic [1:0] spd, logic mode,
                               logic [7:0] dep, logic val, logic st, logic dd, logic rd,
                               logic es);
    item_t it;
    it.opcode            = op;
    it.now_ms            = now;
    it.speed_choice      = spd;
    it.mode_fixed_choice = mode;
    it.depth_choice      = dep;
    it.validate_button   = val;
    it.start_button      = st;
    it.descent_finished  = dd;
    it.return_finished   = rd;
    it.estop_level       = es;
    return it;
  endfunction

  // Mostly plausible operator traffic steered by the predicted phase; some pure noise.
  function automatic item_t next_item();
    item_t       it;
    int unsigned span;
    it = mk(1'($urandom_range(0, 1)), $urandom, 2'($urandom_range(0, 3)),
            1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)));
    if ($urandom_range(0, 99) < 8) begin
      t_now = it.now_ms;
      return it;
    end
    it.opcode = ($urandom_range(0, 99) < 3) ? OpTrigger : OpTick;
    span = {16'd0, (sb.emerg ? sb.rearm : sb.debounce)};
    if ($urandom_range(0, 199) == 0) begin
      t_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    end else begin
      t_now = t_now + $urandom_range(0, 2 * span + 2);
    end
    it.now_ms = t_now;
    if ($urandom_range(0, 4) != 0) it.speed_choice = 2'($urandom_range(1, 3));
    if ($urandom_range(0, 4) != 0) it.depth_choice = 8'($urandom_range(1, 200));
    it.start_button     = ($urandom_range(0, 9) < 4);
    it.descent_finished = ($urandom_range(0, 3) == 0);
    it.return_finished  = ($urandom_range(0, 2) == 0);
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int unsigned gap;
    if (tx_left == 0) begin
      tx_left = $urandom_range(20, 60);
      tx_calm = ($urandom_range(0, 3) == 0);
    end
    tx_left--;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.opcode;
    s_axis_tdata  <= {it.estop_level, it.return_finished, it.descent_finished,
                      it.start_button, it.validate_button, it.depth_choice,
                      it.mode_fixed_choice, it.speed_choice, it.now_ms};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(it);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] deb, input logic [15:0] rea);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegDebounce;
    cfg_wdata_i <= deb;
    @(posedge clk_i);
    cfg_idx_i   <= RegRearm;
    cfg_wdata_i <= rea;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(RegDebounce, deb);
    sb.set_reg(RegRearm, rea);
    settings_run++;
  endtask

  // Result side: a random stall before each transfer, with calm stretches.
  initial begin : result_sink
    int unsigned left;
    bit          calm;
    int unsigned n;
    left = 0;
    calm = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (left == 0) begin
        left = $urandom_range(20, 60);
        calm = ($urandom_range(0, 3) == 0);
      end
      left--;
      n = calm ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] deb;
    logic [15:0] rea;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: debounce 250, rearm 1000
    send_item(mk(OpTick, 32'd0, 2'd0, 1'b0, 8'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'd250, 2'd3, 1'b0, 8'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'd499, 2'd1, 1'b0, 8'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'd500, 2'd1, 1'b0, 8'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'd600, 2'd1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'd700, 2'd1, 1'b0, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'd750, 2'd1, 1'b0, 8'd200, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'd760, 2'd1, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'd770, 2'd1, 1'b0, 8'd1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'd780, 2'd1, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'd790, 2'd1, 1'b0, 8'd1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'd800, 2'd1, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_item(mk(OpTick, 32'd1000, 2'd2, 1'b0, 8'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'd1250, 2'd2, 1'b1, 8'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    // emergency near the top of the time range, rearm across the wrap
    send_item(mk(OpTrigger, 32'hFFFF_FF00, 2'd1, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTrigger, 32'd5, 2'd1, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'hFFFF_FF80, 2'd1, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'h0000_0100, 2'd1, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(mk(OpTick, 32'h0000_02E8, 2'd1, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'h0000_02E9, 2'd1, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk(OpTick, 32'hFFFF_FFFF, 2'd3, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(mk(OpTrigger, 32'hFFFF_FFFF, 2'd3, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(mk(OpTick, 32'd0, 2'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    drain();

    t_now = $urandom;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          deb = 16'd1;
          rea = 16'd0;
        end
        1: begin
          deb = 16'hFFFF;
          rea = 16'hFFFF;
        end
        2: begin
          deb = 16'd0;
          rea = 16'd1;
        end
        3: begin
          deb = 16'($urandom_range(1, 65535));
          rea = 16'($urandom_range(0, 65535));
        end
        4: begin
          deb = DebounceReset;
          rea = RearmReset;
        end
        default: begin
          deb = 16'($urandom_range(1, 20));
          rea = 16'($urandom_range(0, 50));
        end
      endcase
      program_regs(deb, rea);
      repeat (ItemsPerSetting) send_item(next_item());
      drain();
    end

    $display("Checked %0d results over %0d register settings, random gaps on both sides.",
             sb.checked, settings_run + 1);
    $display("Descents %0d, emergency halts %0d, rearms %0d.",
             sb.preps, sb.halts, sb.reenables);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
